### rtl/ccid_serial_frame_receiver_top_defines.svh
// Assertion helpers for the frame receiver.
`ifndef CCID_SERIAL_FRAME_RECEIVER_TOP_DEFINES_SVH
`define CCID_SERIAL_FRAME_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CSFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CSFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/csfr_pkg.sv
package csfr_pkg;

  localparam int HEADER_LENGTH = 10;

  localparam logic [15:0] MAX_PAYLOAD_RESET   = 16'd261;
  localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;

  localparam logic REG_MAX_PAYLOAD   = 1'b0;
  localparam logic REG_TIMEOUT_TICKS = 1'b1;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_CHECK   = 2'd2;

  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_BADCHK  = 2'd1;
  localparam logic [1:0] ST_LONG    = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [16:0] byte_index;
    logic [1:0]  role;
    logic        frame_last;
    logic [1:0]  status;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } res_push_t;

endpackage

### rtl/csfr_in_if.sv
interface csfr_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

### rtl/csfr_out_if.sv
interface csfr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [16:0] byte_index;
  logic [1:0]  role;
  logic        frame_last;
  logic [1:0]  status;

  modport source (output valid, output data_byte, output byte_index, output role,
                  output frame_last, output status, input ready);
  modport sink (input valid, input data_byte, input byte_index, input role,
                input frame_last, input status, output ready);
endinterface

### rtl/csfr_parser.sv
module csfr_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                accept,
  input  logic                kind,
  input  logic [7:0]          rx_byte,
  output csfr_pkg::res_push_t push
);

  logic [15:0] max_payload;
  logic [15:0] timeout_ticks;

  logic [1:0]  phase,          phase_next;
  logic [16:0] position,       position_next;
  logic [31:0] payload_length, payload_length_next;
  logic [7:0]  running_xor,    running_xor_next;
  logic [15:0] idle_count,     idle_count_next;

  logic [15:0] idle_inc;
  logic [31:0] len_or;
  logic [16:0] pos_inc;
  logic [16:0] payload_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload   <= csfr_pkg::MAX_PAYLOAD_RESET;
      timeout_ticks <= csfr_pkg::TIMEOUT_TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csfr_pkg::REG_MAX_PAYLOAD:   max_payload   <= cfg_data;
        csfr_pkg::REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= csfr_pkg::PH_HEADER;
      position       <= '0;
      payload_length <= '0;
      running_xor    <= '0;
      idle_count     <= '0;
    end else begin
      phase          <= phase_next;
      position       <= position_next;
      payload_length <= payload_length_next;
      running_xor    <= running_xor_next;
      idle_count     <= idle_count_next;
    end
  end

  always_comb begin
    idle_inc    = (idle_count != 16'hFFFF) ? idle_count + 16'd1 : idle_count;
    pos_inc     = position + 17'd1;
    payload_end = 17'(csfr_pkg::HEADER_LENGTH) + {1'b0, payload_length[15:0]};

    len_or = payload_length;
    unique case (position)
      17'd1:   len_or[7:0]   = payload_length[7:0]   | rx_byte;
      17'd2:   len_or[15:8]  = payload_length[15:8]  | rx_byte;
      17'd3:   len_or[23:16] = payload_length[23:16] | rx_byte;
      17'd4:   len_or[31:24] = payload_length[31:24] | rx_byte;
      default: ;
    endcase

    phase_next          = phase;
    position_next       = position;
    payload_length_next = payload_length;
    running_xor_next    = running_xor;
    idle_count_next     = idle_count;

    push.valid          = 1'b0;
    push.res.data_byte  = rx_byte;
    push.res.byte_index = position;
    push.res.role       = phase;
    push.res.frame_last = 1'b0;
    push.res.status     = csfr_pkg::ST_GOOD;

    if (accept) begin
      if (kind) begin
        if (position != '0) begin
          idle_count_next = idle_inc;
          if (idle_inc >= timeout_ticks) begin
            push.valid          = 1'b1;
            push.res.data_byte  = '0;
            push.res.frame_last = 1'b1;
            push.res.status     = csfr_pkg::ST_TIMEOUT;
            phase_next          = csfr_pkg::PH_HEADER;
            position_next       = '0;
            payload_length_next = '0;
            running_xor_next    = '0;
            idle_count_next     = '0;
          end
        end
      end else begin
        idle_count_next = '0;
        push.valid      = 1'b1;
        unique case (phase)
          csfr_pkg::PH_HEADER: begin
            payload_length_next = len_or;
            running_xor_next    = running_xor ^ rx_byte;
            position_next       = pos_inc;
            if (pos_inc >= 17'(csfr_pkg::HEADER_LENGTH)) begin
              if (len_or > {16'd0, max_payload}) begin
                push.res.frame_last = 1'b1;
                push.res.status     = csfr_pkg::ST_LONG;
                phase_next          = csfr_pkg::PH_HEADER;
                position_next       = '0;
                payload_length_next = '0;
                running_xor_next    = '0;
              end else begin
                phase_next = (len_or == '0) ? csfr_pkg::PH_CHECK : csfr_pkg::PH_PAYLOAD;
              end
            end
          end
          csfr_pkg::PH_PAYLOAD: begin
            running_xor_next = running_xor ^ rx_byte;
            position_next    = pos_inc;
            if (pos_inc >= payload_end) begin
              phase_next = csfr_pkg::PH_CHECK;
            end
          end
          default: begin
            // check byte, ends the frame
            push.res.role       = csfr_pkg::PH_CHECK;
            push.res.frame_last = 1'b1;
            push.res.status     = (rx_byte == running_xor) ? csfr_pkg::ST_GOOD
                                                           : csfr_pkg::ST_BADCHK;
            phase_next          = csfr_pkg::PH_HEADER;
            position_next       = '0;
            payload_length_next = '0;
            running_xor_next    = '0;
          end
        endcase
      end
    end
  end

endmodule

### rtl/csfr_out_buf.sv
module csfr_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  csfr_pkg::res_push_t push,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output csfr_pkg::res_t      out_res
);

  logic           skid_valid;
  csfr_pkg::res_t skid_res;
  logic           pop;

  assign pop      = out_valid && out_ready;
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || pop) begin
      out_valid <= push.valid;
    end else if (push.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_res <= skid_res;
      end
    end else if (!out_valid || pop) begin
      if (push.valid) begin
        out_res <= push.res;
      end
    end else if (push.valid) begin
      skid_res <= push.res;
    end
  end

endmodule

### rtl/ccid_serial_frame_receiver_top.sv
// Serial frame receiver: takes one byte or tick item per cycle while rx.ready is high and
// gives at most one result item per input item, registered into the output register when
// that is free and else into the skid entry. Frames are a 10-byte header (payload length
// in bytes 1 to 4, little-endian), the payload and an XOR check byte; the frame's last
// result carries good, bad check, too long or timeout. Frame state advances on each accepted
// item; a two-entry output buffer decouples the sides, so rx.ready drops only while both
// entries hold results the sink has not taken. Config writes take effect the next cycle.
`include "ccid_serial_frame_receiver_top_defines.svh"

module ccid_serial_frame_receiver_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data,
  csfr_in_if.sink       rx,
  csfr_out_if.source    res
);

  csfr_pkg::res_push_t push;
  csfr_pkg::res_t      out_res;
  logic                accept;

  assign accept = rx.valid && rx.ready;

  csfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .kind      (rx.kind),
    .rx_byte   (rx.rx_byte),
    .push      (push)
  );

  csfr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_ready  (rx.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_res   (out_res)
  );

  assign res.data_byte  = out_res.data_byte;
  assign res.byte_index = out_res.byte_index;
  assign res.role       = out_res.role;
  assign res.frame_last = out_res.frame_last;
  assign res.status     = out_res.status;

  `CSFR_ASSERT_NOW(a_stall_has_result, !rx.ready, res.valid, "input stalled with no result")
  `CSFR_ASSERT_NOW(a_mid_frame_good, res.valid && !res.frame_last,
                   res.status == csfr_pkg::ST_GOOD, "status set on non-final item")
  `CSFR_ASSERT_NOW(a_check_ends_frame, res.valid && res.role == csfr_pkg::PH_CHECK,
                   res.frame_last, "check byte does not end frame")
  `CSFR_ASSERT_NEXT(a_byte_gives_result, accept && !rx.kind, res.valid,
                    "accepted byte gave no result")

endmodule

### test/csfr_frame_checker.sv
module csfr_frame_checker
  import csfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  csfr_in_if          rx,
  csfr_out_if         res,
  output int          mismatches,
  output int          pending
);

  logic [1:0]  fr_phase;
  logic [16:0] fr_pos;
  logic [31:0] fr_len;
  logic [7:0]  fr_xor;
  logic [15:0] fr_idle;
  logic [15:0] max_len;
  logic [15:0] tick_limit;

  res_t echo_q[$];
  int   n_checked;

  function automatic void clear_frame();
    fr_phase = PH_HEADER;
    fr_pos   = '0;
    fr_len   = '0;
    fr_xor   = '0;
    fr_idle  = '0;
  endfunction

  // one accepted item in, zero or one expected result queued
  function automatic void advance_frame(input logic is_tick, input logic [7:0] b);
    res_t r;
    r = '0;
    r.data_byte  = b;
    r.byte_index = fr_pos;
    r.role       = fr_phase;
    if (is_tick) begin
      if (fr_pos == '0) return;
      if (fr_idle != 16'hFFFF) fr_idle = fr_idle + 16'd1;
      if (fr_idle >= tick_limit) begin
        r.data_byte  = '0;
        r.frame_last = 1'b1;
        r.status     = ST_TIMEOUT;
        echo_q.push_back(r);
        clear_frame();
      end
      return;
    end
    fr_idle = '0;
    case (fr_phase)
      PH_HEADER: begin
        if (fr_pos >= 17'd1 && fr_pos <= 17'd4)
          fr_len = fr_len | ({24'd0, b} << (8 * (fr_pos - 17'd1)));
        fr_xor = fr_xor ^ b;
        if (fr_pos + 17'd1 >= 17'(HEADER_LENGTH)) begin
          if (fr_len > {16'd0, max_len}) begin
            r.frame_last = 1'b1;
            r.status     = ST_LONG;
            echo_q.push_back(r);
            clear_frame();
            return;
          end
          fr_phase = (fr_len == '0) ? PH_CHECK : PH_PAYLOAD;
        end
        fr_pos = fr_pos + 17'd1;
      end
      PH_PAYLOAD: begin
        fr_xor = fr_xor ^ b;
        if ({16'd0, fr_pos} + 33'd1 >= 33'(HEADER_LENGTH) + {1'b0, fr_len})
          fr_phase = PH_CHECK;
        fr_pos = fr_pos + 17'd1;
      end
      default: begin
        r.frame_last = 1'b1;
        r.status     = (b == fr_xor) ? ST_GOOD : ST_BADCHK;
        clear_frame();
      end
    endcase
    echo_q.push_back(r);
  endfunction

  always @(posedge clk) begin
    res_t got, want;
    if (rst) begin
      clear_frame();
      max_len    = MAX_PAYLOAD_RESET;
      tick_limit = TIMEOUT_TICKS_RESET;
      echo_q.delete();
      n_checked  = 0;
      mismatches <= 0;
    end else begin
      if (res.valid && res.ready) begin
        got = {res.data_byte, res.byte_index, res.role, res.frame_last, res.status};
        if (echo_q.size() == 0) begin
          if (mismatches < 10)
            $display("result %0d: unexpected, got data %02h idx %0d role %0d last %0b st %0d",
                     n_checked, got.data_byte, got.byte_index, got.role, got.frame_last,
                     got.status);
          mismatches <= mismatches + 1;
        end else begin
          want = echo_q.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("result %0d: exp data %02h idx %0d role %0d last %0b st %0d, got data %02h idx %0d role %0d last %0b st %0d",
                       n_checked, want.data_byte, want.byte_index, want.role,
                       want.frame_last, want.status, got.data_byte, got.byte_index,
                       got.role, got.frame_last, got.status);
            mismatches <= mismatches + 1;
          end
        end
        n_checked++;
      end
      if (rx.valid && rx.ready) advance_frame(rx.kind, rx.rx_byte);
      if (cfg_we) begin
        if (cfg_index == REG_MAX_PAYLOAD) max_len = cfg_data;
        else tick_limit = cfg_data;
      end
    end
    pending <= echo_q.size();
  end

endmodule

### test/ccid_serial_frame_receiver_top_tb.sv
module ccid_serial_frame_receiver_top_tb;
  import csfr_pkg::*;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_TICK   = 1'b1;
  localparam int   STALL_LIMIT = 2000;
  localparam int   HOLD_CYCLES = 300;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  int          mismatches;
  int          pending;

  int          send_quiet, take_quiet;
  int          n_bytes, n_ticks, n_frames, n_settings, taken, stall;
  logic [15:0] cur_max, cur_timeout;

  csfr_in_if  in_ch();
  csfr_out_if out_ch();

  ccid_serial_frame_receiver_top DUT (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .rx(in_ch), .res(out_ch)
  );

  csfr_frame_checker u_frame_chk (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .rx(in_ch), .res(out_ch),
    .mismatches, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) quiet = $urandom_range(10, 50);
    return $urandom_range(0, 16);
  endfunction

  task automatic send_item(input logic k, input logic [7:0] b);
    int gap;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= k;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (k == KIND_TICK) n_ticks++;
    else n_bytes++;
  endtask

  task automatic maybe_ticks(input int tick_max);
    if (tick_max > 0 && $urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, tick_max)) send_item(KIND_TICK, 8'($urandom));
  endtask

  task automatic send_header(input logic [31:0] len_field, input int tick_max,
                             output logic [7:0] sum);
    logic [7:0] b;
    sum = '0;
    for (int i = 0; i < HEADER_LENGTH; i++) begin
      if (i >= 1 && i <= 4) b = len_field[8*(i-1) +: 8];
      else b = 8'($urandom);
      send_item(KIND_BYTE, b);
      sum = sum ^ b;
      maybe_ticks(tick_max);
    end
  endtask

  task automatic send_bytes(input int n, input int tick_max, inout logic [7:0] sum);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      send_item(KIND_BYTE, b);
      sum = sum ^ b;
      maybe_ticks(tick_max);
    end
  endtask

  task automatic send_frame(input logic [31:0] len_field, input int n_payload,
                            input bit corrupt, input int tick_max);
    logic [7:0] sum;
    send_header(len_field, tick_max, sum);
    send_bytes(n_payload, tick_max, sum);
    send_item(KIND_BYTE, corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
    n_frames++;
  endtask

  // only while idle: drain results, then let the last item settle
  task automatic write_reg(input logic idx, input logic [15:0] value);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_PAYLOAD) cur_max = value;
    else cur_timeout = value;
    n_settings++;
  endtask

  // pull the block back to the frame start after a broken sequence
  task automatic flush_frame();
    repeat (cur_timeout) send_item(KIND_TICK, 8'($urandom));
  endtask

  initial begin
    logic [7:0] sum;
    int         len, pick, start;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_MAX_PAYLOAD;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.kind    <= KIND_BYTE;
    in_ch.rx_byte <= '0;
    cur_max     = MAX_PAYLOAD_RESET;
    cur_timeout = TIMEOUT_TICKS_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings
    send_item(KIND_TICK, 8'hFF);
    repeat (HEADER_LENGTH + 1) send_item(KIND_BYTE, 8'h00);
    repeat (HEADER_LENGTH) send_item(KIND_BYTE, 8'hFF);
    send_frame(32'd3, 3, 1'b0, 4);
    send_frame(32'd2, 2, 1'b1, 0);
    send_header(32'(MAX_PAYLOAD_RESET) + 32'd1, 0, sum);

    // zero limits: every nonzero length too long, first tick in a frame times out
    write_reg(REG_MAX_PAYLOAD, 16'd0);
    write_reg(REG_TIMEOUT_TICKS, 16'd0);
    send_frame(32'd0, 0, 1'b0, 0);
    send_item(KIND_BYTE, 8'($urandom));
    send_item(KIND_TICK, 8'h00);
    send_header(32'd1, 0, sum);

    // timeout in each phase
    write_reg(REG_MAX_PAYLOAD, 16'd5);
    write_reg(REG_TIMEOUT_TICKS, 16'd3);
    repeat (4) send_item(KIND_BYTE, 8'($urandom));
    repeat (3) send_item(KIND_TICK, 8'($urandom));
    send_header(32'd2, 0, sum);
    send_item(KIND_BYTE, 8'($urandom));
    repeat (3) send_item(KIND_TICK, 8'($urandom));
    send_header(32'd0, 0, sum);
    repeat (3) send_item(KIND_TICK, 8'($urandom));

    // widest settings, length in the upper bytes
    write_reg(REG_MAX_PAYLOAD, 16'hFFFF);
    write_reg(REG_TIMEOUT_TICKS, 16'hFFFF);
    send_header(32'h0001_0000, 0, sum);
    send_frame(32'd4, 4, 1'b0, 0);

    for (int s = 0; s < 8; s++) begin
      write_reg(REG_MAX_PAYLOAD, 16'($urandom_range(0, 40)));
      write_reg(REG_TIMEOUT_TICKS, 16'($urandom_range(1, 30)));
      start = n_bytes + n_ticks;
      while (n_bytes + n_ticks - start < 40) begin
        pick = $urandom_range(0, 9);
        len  = $urandom_range(0, int'(cur_max) + 3);
        if (pick < 7) begin
          if (len > cur_max) send_header(len, int'(cur_timeout) - 1, sum);
          else send_frame(len, len, $urandom_range(0, 3) == 0, int'(cur_timeout) - 1);
        end else if (pick == 7) begin
          if ($urandom_range(0, 1) == 0) begin
            send_header($urandom, int'(cur_timeout) - 1, sum);
          end else begin
            send_header(len, 0, sum);
            send_bytes($urandom_range(0, len), 0, sum);
          end
          flush_frame();
        end else begin
          repeat ($urandom_range(1, 6))
            send_item(1'($urandom_range(0, 1)), 8'($urandom));
          flush_frame();
        end
      end
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    $display("sent %0d bytes and %0d ticks, %0d whole frames, over %0d register writes",
             n_bytes, n_ticks, n_frames, n_settings);
    $display("covered all phases, timeouts, length aborts, bad checks and upper length bytes");
    if (mismatches == 0 && pending == 0) begin
      $display("ccid_serial_frame_receiver_top_tb passed");
    end else begin
      $display("ccid_serial_frame_receiver_top_tb failed");
    end
    $finish;
  end

  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (taken == 40 || taken == 300) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = draw_gap(take_quiet);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall <= 0;
    end else if (stall >= STALL_LIMIT) begin
      $display("ccid_serial_frame_receiver_top_tb failed");
      $finish;
    end else begin
      stall <= stall + 1;
    end
  end

endmodule

### sim.f
+incdir+rtl
rtl/csfr_pkg.sv
rtl/csfr_in_if.sv
rtl/csfr_out_if.sv
rtl/csfr_parser.sv
rtl/csfr_out_buf.sv
rtl/ccid_serial_frame_receiver_top.sv
test/csfr_frame_checker.sv
test/ccid_serial_frame_receiver_top_tb.sv
